[rtl/core/sip_pkg.sv]
// Shared types and constants for the slab intensity projection block.
// Used by every module under rtl/core; depends on nothing.
`timescale 1ns / 1ps
package sip_pkg;

  localparam int PIX_W      = 16;
  localparam int ACC_W      = 26;
  localparam int POS_W      = 18;
  localparam int SLC_W      = 10;
  localparam int SCNT_W     = 11;
  localparam int PCNT_W     = 19;
  localparam int CFG_W      = 19;
  localparam int IDX_W      = 2;
  localparam int MAX_SLICES = 1024;
  localparam int MAX_PIXELS = 262144;
  localparam int NUM_W      = ACC_W + 1;
  localparam int DEN_W      = SCNT_W + 1;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int FIFO_LW    = 4;

  localparam logic [1:0] MODE_MAX = 2'd0;
  localparam logic [1:0] MODE_MIN = 2'd1;
  localparam logic [1:0] MODE_AVG = 2'd2;

  localparam logic [IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [IDX_W-1:0] REG_SLICES = 2'd1;
  localparam logic [IDX_W-1:0] REG_PIXELS = 2'd2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [SCNT_W-1:0] slices;
    logic [PCNT_W-1:0] pixels;
  } sip_cfg_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    logic [POS_W-1:0]        pos;
    logic                    last;
    logic                    avg;
  } sip_item_t;

  typedef struct packed {
    logic               not_empty;
    logic [FIFO_LW-1:0] level;
  } sip_qstat_t;

endpackage

[rtl/core/sip_fifo.sv]
// Short request queue between the accumulate front and the divide back.
// Depends on sip_pkg.
`timescale 1ns / 1ps
module sip_fifo
  import sip_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  sip_item_t  push_item,
  input  logic       pop,
  output sip_item_t  head,
  output sip_qstat_t qstat
);

  sip_item_t          mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_LW-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

  assign head            = mem_r[rd_ptr_r];
  assign qstat.not_empty = (cnt_r != '0);
  assign qstat.level     = cnt_r;

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> cnt_r != FIFO_LW'(FIFO_DEPTH))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0)
    else $error("queue underflow");
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FIFO_LW'(FIFO_DEPTH))
    else $error("queue level out of range");
`endif

endmodule

[rtl/core/sip_front.sv]
// Front: position/slice counters, accumulator memory read-modify-write.
// Pushes one request per last-slice pixel into the queue. Depends on sip_pkg.
`timescale 1ns / 1ps
module sip_front
  import sip_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  sip_cfg_t         cfg,
  input  logic             restart,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [PIX_W-1:0] in_pixel_value,
  input  sip_qstat_t       qstat,
  output logic             push,
  output sip_item_t        push_item
);

  logic [ACC_W-1:0] acc_mem [MAX_PIXELS];

  logic [POS_W-1:0] pos_r;
  logic [SLC_W-1:0] slc_r;
  logic             s0_vld_r;
  logic [PIX_W-1:0] s0_pix_r;
  logic [POS_W-1:0] s0_pos_r;
  logic             s0_first_r;
  logic             s0_emit_r;
  logic             s0_last_r;
  logic [ACC_W-1:0] rd_data_r;
  logic             wr_vld_r;
  logic [POS_W-1:0] wr_addr_r;
  logic [ACC_W-1:0] wr_data_r;

  logic                    accept;
  logic                    last_pos;
  logic                    last_slc;
  logic signed [ACC_W-1:0] pix_ext;
  logic signed [ACC_W-1:0] old_acc;
  logic signed [ACC_W-1:0] acc_nxt;

  // Keep room for the request in flight plus the one being accepted.
  assign in_ready = (qstat.level <= FIFO_LW'(FIFO_DEPTH - 2));
  assign accept   = in_valid && in_ready;
  assign last_pos = ({1'b0, pos_r} == cfg.pixels - PCNT_W'(1));
  assign last_slc = ({1'b0, slc_r} == cfg.slices - SCNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      slc_r    <= '0;
      s0_vld_r <= 1'b0;
      wr_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= accept;
      wr_vld_r <= s0_vld_r;
      if (restart) begin
        pos_r <= '0;
        slc_r <= '0;
      end else if (accept) begin
        if (last_pos) begin
          pos_r <= '0;
          slc_r <= last_slc ? '0 : slc_r + 1'b1;
        end else begin
          pos_r <= pos_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_pix_r   <= in_pixel_value;
      s0_pos_r   <= pos_r;
      s0_first_r <= (slc_r == '0);
      s0_emit_r  <= last_slc;
      s0_last_r  <= last_pos;
    end
    wr_addr_r <= s0_pos_r;
    wr_data_r <= acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (s0_vld_r) acc_mem[s0_pos_r] <= acc_nxt;
    if (accept)   rd_data_r <= acc_mem[pos_r];
  end

  // Forward the write of the previous cycle when it hit the same position.
  always_comb begin
    pix_ext = {{(ACC_W - PIX_W){s0_pix_r[PIX_W-1]}}, s0_pix_r};
    old_acc = (wr_vld_r && wr_addr_r == s0_pos_r) ? wr_data_r : rd_data_r;
    if (s0_first_r) begin
      acc_nxt = pix_ext;
    end else begin
      case (cfg.mode)
        MODE_MIN: acc_nxt = (pix_ext < old_acc) ? pix_ext : old_acc;
        MODE_AVG: acc_nxt = old_acc + pix_ext;
        default:  acc_nxt = (pix_ext > old_acc) ? pix_ext : old_acc;
      endcase
    end
  end

  assign push           = s0_vld_r && s0_emit_r;
  assign push_item.acc  = acc_nxt;
  assign push_item.pos  = s0_pos_r;
  assign push_item.last = s0_last_r;
  assign push_item.avg  = (cfg.mode == MODE_AVG);

`ifndef ASSERT_OFF
  a_pos_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    s0_vld_r |-> {1'b0, s0_pos_r} < cfg.pixels)
    else $error("position beyond block");
  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> qstat.level < FIFO_LW'(FIFO_DEPTH))
    else $error("push without queue credit");
`endif

endmodule

[rtl/core/sip_back.sv]
// Back: pipelined restoring divider for the rounded average, one quotient
// bit per stage, plus the input register. Depends on sip_pkg.
`timescale 1ns / 1ps
module sip_back
  import sip_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  sip_cfg_t          cfg,
  input  sip_item_t         head,
  input  sip_qstat_t        qstat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PIX_W-1:0]  out_projected_value,
  output logic [POS_W-1:0]  out_pixel_index,
  output logic              out_last_pixel
);

  logic [DEN_W-1:0] rem_r  [NUM_W+1];
  logic [NUM_W-1:0] nq_r   [NUM_W+1];
  logic             vld_r  [NUM_W+1];
  logic             neg_r  [NUM_W+1];
  logic             avg_r  [NUM_W+1];
  logic [PIX_W-1:0] val_r  [NUM_W+1];
  logic [POS_W-1:0] pos_r  [NUM_W+1];
  logic             last_r [NUM_W+1];

  logic             en;
  logic [DEN_W-1:0] den;
  logic [ACC_W-1:0] mag;
  logic [NUM_W-1:0] num;
  logic [PIX_W-1:0] quo;

  // Advance all stages together; hold when the output is stalled.
  assign en  = !vld_r[NUM_W] || out_ready;
  assign pop = en && qstat.not_empty;
  assign den = {cfg.slices, 1'b0};
  assign mag = head.acc[ACC_W-1] ? ACC_W'(-head.acc) : ACC_W'(head.acc);
  assign num = {mag, 1'b0} + NUM_W'(cfg.slices);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= '0;
      nq_r[0]   <= num;
      neg_r[0]  <= head.acc[ACC_W-1];
      avg_r[0]  <= head.avg;
      val_r[0]  <= head.acc[PIX_W-1:0];
      pos_r[0]  <= head.pos;
      last_r[0] <= head.last;
    end
  end

  for (genvar k = 1; k <= NUM_W; k++) begin : g_stage
    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W-1:0] rem_nxt;

    assign trial   = {rem_r[k-1], nq_r[k-1][NUM_W-1]};
    assign ge      = (trial >= {1'b0, den});
    assign rem_nxt = ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        nq_r[k]   <= {nq_r[k-1][NUM_W-2:0], ge};
        neg_r[k]  <= neg_r[k-1];
        avg_r[k]  <= avg_r[k-1];
        val_r[k]  <= val_r[k-1];
        pos_r[k]  <= pos_r[k-1];
        last_r[k] <= last_r[k-1];
      end
    end
  end

  assign quo                 = nq_r[NUM_W][PIX_W-1:0];
  assign out_valid           = vld_r[NUM_W];
  assign out_projected_value = avg_r[NUM_W] ? (neg_r[NUM_W] ? PIX_W'(-quo) : quo)
                                            : val_r[NUM_W];
  assign out_pixel_index     = pos_r[NUM_W];
  assign out_last_pixel      = last_r[NUM_W];

endmodule

[rtl/core/slab_intensity_projection.sv]
// Top level of the slab intensity projection block: configuration registers
// and the front / queue / back chain. Depends on sip_pkg, sip_front,
// sip_fifo and sip_back.
//
// Usage:
//   - in_*: one signed pixel per request, slice by slice, raster order.
//   - out_*: during the last slice of a projection, one result per pixel
//     (max, min or rounded average), its index, and last_pixel at the end.
//   - cfg_*: write mode, slice count and pixel count while idle; any write
//     to a listed register restarts the projection at pixel 0, slice 0.
// Path: an accepted pixel passes the memory read and accumulate register,
// the queue, the divider's input register and its divider stages, then
// reaches out_valid; a receiver stall holds it in the divider.
// Throughput: one pixel per cycle while in_ready is high, set by the
// accumulator memory doing one read and one write per cycle; back-to-back
// writes to one position are forwarded.
// Reset: counters clear, registers go to max mode, 1 slice, 262144 pixels.
// Accumulators are not cleared; the first slice loads them.
// Receiver stall: the divider pipeline holds, the queue fills, and in_ready
// drops once the queue cannot take the pixels in flight.
`timescale 1ns / 1ps
module slab_intensity_projection
  import sip_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PIX_W-1:0]  in_pixel_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PIX_W-1:0]  out_projected_value,
  output logic [POS_W-1:0]  out_pixel_index,
  output logic              out_last_pixel
);

  logic [1:0]        mode_r;
  logic [SCNT_W-1:0] slices_r;
  logic [PCNT_W-1:0] pixels_r;
  logic              restart;

  sip_cfg_t   cfg;
  sip_qstat_t qstat;
  sip_item_t  push_item;
  sip_item_t  head;
  logic       push;
  logic       pop;

  // Decode register writes; unlisted indexes are dropped.
  always_comb begin
    unique case (cfg_index)
      REG_MODE, REG_SLICES, REG_PIXELS: restart = cfg_we;
      default:                          restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_MAX;
      slices_r <= SCNT_W'(1);
      pixels_r <= PCNT_W'(MAX_PIXELS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:   mode_r   <= cfg_wdata[1:0];
        REG_SLICES: slices_r <= cfg_wdata[SCNT_W-1:0];
        REG_PIXELS: pixels_r <= cfg_wdata[PCNT_W-1:0];
        default:    ;
      endcase
    end
  end

  // Clamp counts into their legal ranges; zero acts as one.
  assign cfg.mode   = mode_r;
  assign cfg.slices = (slices_r == '0) ? SCNT_W'(1)
                    : (slices_r > SCNT_W'(MAX_SLICES)) ? SCNT_W'(MAX_SLICES) : slices_r;
  assign cfg.pixels = (pixels_r == '0) ? PCNT_W'(1)
                    : (pixels_r > PCNT_W'(MAX_PIXELS)) ? PCNT_W'(MAX_PIXELS) : pixels_r;

  sip_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .restart        (restart),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_value (in_pixel_value),
    .qstat          (qstat),
    .push           (push),
    .push_item      (push_item)
  );

  sip_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  sip_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg),
    .head                (head),
    .qstat               (qstat),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_projected_value (out_projected_value),
    .out_pixel_index     (out_pixel_index),
    .out_last_pixel      (out_last_pixel)
  );

endmodule
